// ===== design/apab_pkg.sv =====
package apab_pkg;

    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int QUOT_W   = 8;
    localparam int PIPE_LAT = QUOT_W + 3;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    typedef enum logic [1:0] {
        OP_SRC_OVER  = 2'd0,
        OP_MASK_OVER = 2'd1,
        OP_MASK_KEEP = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef struct packed {
        logic              mask_over;
        logic              we;
        logic [CHAN_W-1:0] alpha;
    } t_ctl;

    // exact floor(x / 255) for x up to 65279
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'(x >> 8) + 17'd1;
        return t[15:8];
    endfunction

    function automatic logic [CHAN_W-1:0] sat8(input logic [CHAN_W:0] v);
        return v[CHAN_W] ? CHAN_MAX : v[CHAN_W-1:0];
    endfunction

endpackage

// ===== design/apab_div.sv =====
module apab_div #(
    parameter int LANES  = 3,
    parameter int NUM_W  = 24,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [LANES*NUM_W-1:0]                i_num,
    input  logic [DEN_W-1:0]                      i_den,
    input  logic [SIDE_W-1:0]                     i_side,
    output logic                                  o_valid,
    output logic [LANES*apab_pkg::QUOT_W-1:0]     o_quot,
    output logic [SIDE_W-1:0]                     o_side
);
    import apab_pkg::*;

    localparam int W = (NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W;

    logic [W-1:0]      r_rem  [QUOT_W][LANES];
    logic [QUOT_W-1:0] r_quot [QUOT_W][LANES];
    logic [DEN_W-1:0]  r_den  [QUOT_W];
    logic [SIDE_W-1:0] r_side [QUOT_W];
    logic [QUOT_W-1:0] r_valid;

    // one quotient bit per stage, msb first
    for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
        logic [W-1:0]      rem_in  [LANES];
        logic [QUOT_W-1:0] quot_in [LANES];
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic              valid_in;
        logic [W-1:0]      shd;
        logic [W-1:0]      n_rem   [LANES];
        logic [QUOT_W-1:0] n_quot  [LANES];

        if (s == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l]  = W'(i_num[l*NUM_W +: NUM_W]);
                    quot_in[l] = '0;
                end
            end
            assign den_in   = i_den;
            assign side_in  = i_side;
            assign valid_in = i_valid;
        end else begin : g_next
            assign rem_in   = r_rem[s-1];
            assign quot_in  = r_quot[s-1];
            assign den_in   = r_den[s-1];
            assign side_in  = r_side[s-1];
            assign valid_in = r_valid[s-1];
        end

        assign shd = W'(den_in) << (QUOT_W - 1 - s);

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                n_quot[l] = quot_in[l];
                if (rem_in[l] >= shd) begin
                    n_rem[l] = rem_in[l] - shd;
                    n_quot[l][QUOT_W-1-s] = 1'b1;
                end else begin
                    n_rem[l] = rem_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_quot[s] <= n_quot;
            r_den[s]  <= den_in;
            r_side[s] <= side_in;
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quot[l*QUOT_W +: QUOT_W] = r_quot[QUOT_W-1][l];
        end
    end

    assign o_valid = r_valid[QUOT_W-1];
    assign o_side  = r_side[QUOT_W-1];

endmodule

// ===== design/argb_pixel_alpha_blend.sv =====
// path: an accepted item passes the stage 1 and stage 2 registers, the divider and the output register to o_done
// throughput: one item per clock whenever busy is low, no dependence between items
// that path is the 8-stage restoring divider plus two multiply stages and the output register
// synchronous active-low reset clears the pipeline valids and the fill color to 0
// busy is high only in reset and the first cycle after it; results cannot be stalled
module argb_pixel_alpha_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_dest_pixel,
    input  logic [31:0] i_source_pixel,
    input  logic [7:0]  i_coverage,
    output logic        o_done,
    output logic [31:0] o_out_pixel,
    output logic        o_write_enable
);
    import apab_pkg::*;

    logic        r_busy;
    logic [23:0] r_fill;

    // stage 1: products
    t_op         in_op;
    logic [7:0]  la;
    logic [23:0] ls;
    logic        r1_valid;
    t_op         r1_op;
    logic [31:0] r1_dest;
    logic [7:0]  r1_cov;
    logic [7:0]  r1_la;
    logic [15:0] r1_pd [NUM_CHAN];
    logic [15:0] r1_ps [NUM_CHAN];
    logic [15:0] r1_n2 [NUM_CHAN];
    logic [15:0] r1_dasa;
    logic [15:0] r1_p;

    // stage 2: lerp result, combined alpha, numerators
    logic [31:0] lerp_pix;
    logic [8:0]  a9;
    logic [7:0]  mask_a;
    logic        we;
    logic        r2_valid;
    t_ctl        r2_ctl;
    logic [31:0] r2_pix;
    logic [15:0] r2_den;
    logic [23:0] r2_n1 [NUM_CHAN];
    logic [15:0] r2_n2 [NUM_CHAN];
    logic [NUM_CHAN*24-1:0] num1;
    logic [NUM_CHAN*16-1:0] num2;

    // divider outputs
    logic                         div_a_valid;
    logic                         div_b_valid;
    logic [NUM_CHAN*QUOT_W-1:0]   quot1;
    logic [NUM_CHAN*QUOT_W-1:0]   quot2;
    logic [$bits(t_ctl)-1:0]      ctl_bits;
    t_ctl                         ctl_d;
    logic [31:0]                  pix_d;
    logic [23:0]                  mask_rgb;

    logic        r_done;
    logic [31:0] r_out_pixel;
    logic        r_we;

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_fill <= '0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fill <= i_cfg_data;
            end
        end
    end

    assign in_op = t_op'(i_op);
    assign la    = (in_op == OP_SRC_OVER) ? i_source_pixel[31:24] : i_coverage;
    assign ls    = (in_op == OP_SRC_OVER) ? i_source_pixel[23:0] : r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_op   <= in_op;
        r1_dest <= i_dest_pixel;
        r1_cov  <= i_coverage;
        r1_la   <= la;
        r1_dasa <= 16'(i_dest_pixel[31:24]) * 16'(i_coverage);
        r1_p    <= 16'(CHAN_MAX - i_coverage) * 16'(i_dest_pixel[31:24]);
        for (int c = 0; c < NUM_CHAN; c++) begin
            r1_pd[c] <= 16'(i_dest_pixel[c*CHAN_W +: CHAN_W]) * 16'(CHAN_MAX - la);
            r1_ps[c] <= 16'(ls[c*CHAN_W +: CHAN_W]) * 16'(la);
            r1_n2[c] <= 16'(i_coverage) * 16'(r_fill[c*CHAN_W +: CHAN_W]);
        end
    end

    always_comb begin
        lerp_pix[31:24] = r1_dest[31:24];
        for (int c = 0; c < NUM_CHAN; c++) begin
            lerp_pix[c*CHAN_W +: CHAN_W] =
                sat8(9'(div255(r1_pd[c])) + 9'(div255(r1_ps[c])));
        end
    end

    assign a9     = {1'b0, r1_dest[31:24]} + {1'b0, r1_cov} - {1'b0, div255(r1_dasa)};
    assign mask_a = a9[7:0];

    always_comb begin
        unique case (r1_op) inside
            OP_SRC_OVER, OP_MASK_KEEP: we = (r1_la != 8'd0);
            OP_MASK_OVER:              we = (r1_dest[31:24] != 8'd0) || (r1_cov != 8'd0);
            default:                   we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_ctl.mask_over <= we && (r1_op == OP_MASK_OVER);
        r2_ctl.we        <= we;
        r2_ctl.alpha     <= mask_a;
        r2_pix           <= (we && (r1_op != OP_MASK_OVER)) ? lerp_pix : r1_dest;
        r2_den           <= {mask_a, 8'h00} - 16'(mask_a);
        for (int c = 0; c < NUM_CHAN; c++) begin
            r2_n1[c] <= 24'(r1_p) * 24'(r1_dest[c*CHAN_W +: CHAN_W]);
            r2_n2[c] <= r1_n2[c];
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            num1[c*24 +: 24] = r2_n1[c];
            num2[c*16 +: 16] = r2_n2[c];
        end
    end

    // dest term over 255*alpha
    apab_div #(
        .LANES  (NUM_CHAN),
        .NUM_W  (24),
        .DEN_W  (16),
        .SIDE_W ($bits(t_ctl))
    ) u_div_dest (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_valid),
        .i_num   (num1),
        .i_den   (r2_den),
        .i_side  (r2_ctl),
        .o_valid (div_a_valid),
        .o_quot  (quot1),
        .o_side  (ctl_bits)
    );

    // fill term over alpha
    apab_div #(
        .LANES  (NUM_CHAN),
        .NUM_W  (16),
        .DEN_W  (8),
        .SIDE_W (32)
    ) u_div_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_valid),
        .i_num   (num2),
        .i_den   (r2_ctl.alpha),
        .i_side  (r2_pix),
        .o_valid (div_b_valid),
        .o_quot  (quot2),
        .o_side  (pix_d)
    );

    assign ctl_d = t_ctl'(ctl_bits);

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            mask_rgb[c*CHAN_W +: CHAN_W] = sat8(9'(quot1[c*QUOT_W +: QUOT_W])
                                              + 9'(quot2[c*QUOT_W +: QUOT_W]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= div_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pixel <= ctl_d.mask_over ? {ctl_d.alpha, mask_rgb} : pix_d;
        r_we        <= ctl_d.we;
    end

    assign o_done         = r_done;
    assign o_out_pixel    = r_out_pixel;
    assign o_write_enable = r_we;

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_a_valid == div_b_valid)
        else $error("divider lanes out of step");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_done)
        else $error("accepted item produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without accepted item");

endmodule
